@@ rtl/rrf_pkg.sv @@
// ----------------------------------------------------------------------------
// rrf_pkg
// Shared types and constants of the radial repulsion force unit.
// ----------------------------------------------------------------------------
package rrf_pkg;

	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 32;

	localparam logic [CfgIdxW-1:0] CFG_CENTER_X = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_CENTER_Y = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_CENTER_Z = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_STRENGTH = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_OUTER = 3'd4;
	localparam logic [CfgIdxW-1:0] CFG_INNER = 3'd5;
	localparam logic [CfgIdxW-1:0] CFG_CONSUME = 3'd6;

	localparam logic [31:0] OUTER_RESET = 32'd3276800;
	localparam logic [30:0] INNER_RESET = 31'd655360;

	localparam int Latency = 58;

	typedef struct packed {
		logic signed [31:0] particle_x;
		logic signed [31:0] particle_y;
		logic signed [31:0] particle_z;
		logic [30:0] particle_mass;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] force_x;
		logic signed [31:0] force_y;
		logic signed [31:0] force_z;
		logic apply_force;
		logic kill_particle;
	} out_word_t;

endpackage

@@ rtl/radial_repulsion_force_unit.sv @@
// ----------------------------------------------------------------------------
// radial_repulsion_force_unit
// Repulsion force from a centre point with linear falloff, fully pipelined.
// ----------------------------------------------------------------------------
// throughput: one word per cycle; busy stays low, the receiver cannot stall
// depth set by the 34-step square root and the 17-step dividers
// reset clears the valid chain and loads the register reset values
module radial_repulsion_force_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  rrf_pkg::in_word_t             particle,
	output logic                          done,
	output rrf_pkg::out_word_t            result,
	input  logic                          cfg_we,
	input  logic [rrf_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [rrf_pkg::CfgDataW-1:0]  cfg_data
);

	localparam int SqSteps = 34;
	localparam int DvSteps = 17;

	typedef struct packed {
		logic [2:0][32:0] m;
		logic [2:0] neg;
		logic [46:0] sm;
		logic zero;
	} carry_t;

	typedef struct packed {
		logic [2:0][16:0] unit;
		logic [2:0] neg;
		logic [46:0] sm;
		logic apply;
		logic kill;
	} dv_carry_t;

	logic [31:0] center_x_q, center_y_q, center_z_q, strength_q, outer_q;
	logic [30:0] inner_q;
	logic consume_q;

	logic [rrf_pkg::Latency-1:0] vld_q;

	logic [2:0][32:0] m_s1;
	logic [2:0] neg_s1;
	logic [30:0] mass_s1;

	logic [2:0][65:0] sq_s2;
	carry_t c_s2;

	logic [66:0] sum_s3;
	carry_t c_s3;

	logic [66:0] rem_s4 [SqSteps+1];
	logic [33:0] root_s4 [SqSteps+1];
	carry_t c_s4 [SqSteps+1];

	logic [33:0] dist_s5;
	carry_t c_s5;
	logic apply_s5, kill_s5;
	logic apply_s5_d, kill_s5_d;

	logic [3:0][49:0] drem_s6 [DvSteps+1];
	logic [3:0][16:0] q_s6 [DvSteps+1];
	logic [33:0] dsr_s6 [DvSteps+1];
	dv_carry_t c_s6 [DvSteps+1];

	logic [47:0] mag_s7;
	dv_carry_t c_s7;
	logic [2:0][48:0] f_s8;
	dv_carry_t c_s8;

	rrf_pkg::out_word_t out_q;

	logic [31:0] smag;
	logic [2:0][32:0] d_comb;
	logic [2:0][31:0] sat;
	logic [16:0] pct;

	assign busy = 1'b0;
	assign done = vld_q[rrf_pkg::Latency-1];
	assign result = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			strength_q <= '0;
			outer_q <= rrf_pkg::OUTER_RESET;
			inner_q <= rrf_pkg::INNER_RESET;
			consume_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				rrf_pkg::CFG_CENTER_X: center_x_q <= cfg_data;
				rrf_pkg::CFG_CENTER_Y: center_y_q <= cfg_data;
				rrf_pkg::CFG_CENTER_Z: center_z_q <= cfg_data;
				rrf_pkg::CFG_STRENGTH: strength_q <= cfg_data;
				rrf_pkg::CFG_OUTER: outer_q <= cfg_data;
				rrf_pkg::CFG_INNER: inner_q <= cfg_data[30:0];
				rrf_pkg::CFG_CONSUME: consume_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[rrf_pkg::Latency-2:0], start & ~busy};
		end
	end

	// offsets
	always_comb begin
		d_comb[0] = {particle.particle_x[31], particle.particle_x} - {center_x_q[31], center_x_q};
		d_comb[1] = {particle.particle_y[31], particle.particle_y} - {center_y_q[31], center_y_q};
		d_comb[2] = {particle.particle_z[31], particle.particle_z} - {center_z_q[31], center_z_q};
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			neg_s1[i] <= d_comb[i][32];
			m_s1[i] <= d_comb[i][32] ? 33'(-d_comb[i]) : d_comb[i];
		end
		mass_s1 <= particle.particle_mass;
	end

	assign smag = strength_q[31] ? 32'(-strength_q) : strength_q;

	// squares and strength times mass
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= 66'(m_s1[i]) * 66'(m_s1[i]);
		end
		c_s2.m <= m_s1;
		c_s2.neg <= neg_s1;
		c_s2.sm <= 47'((64'(smag) * 64'(mass_s1)) >> 16);
		c_s2.zero <= (m_s1 == '0);
	end

	always_ff @(posedge clk) begin
		sum_s3 <= 67'(sq_s2[0]) + 67'(sq_s2[1]) + 67'(sq_s2[2]);
		c_s3 <= c_s2;
	end

	// square root, one root bit per stage
	assign rem_s4[0] = sum_s3;
	assign root_s4[0] = '0;
	assign c_s4[0] = c_s3;

	for (genvar k = 0; k < SqSteps; k++) begin : g_sqrt
		localparam int B = SqSteps - 1 - k;
		logic [69:0] trial;
		assign trial = (70'(root_s4[k]) << (B + 1)) + (70'(1) << (2 * B));
		always_ff @(posedge clk) begin
			c_s4[k+1] <= c_s4[k];
			if (70'(rem_s4[k]) >= trial) begin
				rem_s4[k+1] <= rem_s4[k] - trial[66:0];
				root_s4[k+1] <= root_s4[k] | (34'(1) << B);
			end else begin
				rem_s4[k+1] <= rem_s4[k];
				root_s4[k+1] <= root_s4[k];
			end
		end
	end

	// region checks
	always_comb begin
		logic beyond, dead;
		beyond = ~outer_q[31] && (root_s4[SqSteps] > {2'b0, outer_q});
		dead = root_s4[SqSteps] < {3'b0, inner_q};
		apply_s5_d = ~c_s4[SqSteps].zero && ~beyond && ~dead;
		kill_s5_d = ~c_s4[SqSteps].zero && ~beyond && dead && consume_q;
	end

	always_ff @(posedge clk) begin
		dist_s5 <= root_s4[SqSteps];
		c_s5 <= c_s4[SqSteps];
		apply_s5 <= apply_s5_d;
		kill_s5 <= kill_s5_d;
	end

	// unit vector lanes and falloff lane, one quotient bit per stage
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			drem_s6[0][i] = {1'b0, c_s5.m[i], 16'b0};
			c_s6[0].unit[i] = '0;
		end
		drem_s6[0][3] = {dist_s5, 16'b0};
		q_s6[0] = '0;
		dsr_s6[0] = dist_s5;
		c_s6[0].neg = c_s5.neg;
		c_s6[0].sm = c_s5.sm;
		c_s6[0].apply = apply_s5;
		c_s6[0].kill = kill_s5;
	end

	for (genvar k = 0; k < DvSteps; k++) begin : g_div
		localparam int J = DvSteps - 1 - k;
		always_ff @(posedge clk) begin
			for (int i = 0; i < 4; i++) begin
				logic [50:0] trial;
				trial = (i == 3) ? (51'(outer_q[30:0]) << J) : (51'(dsr_s6[k]) << J);
				if (51'(drem_s6[k][i]) >= trial) begin
					drem_s6[k+1][i] <= drem_s6[k][i] - trial[49:0];
					q_s6[k+1][i] <= q_s6[k][i] | (17'(1) << J);
				end else begin
					drem_s6[k+1][i] <= drem_s6[k][i];
					q_s6[k+1][i] <= q_s6[k][i];
				end
			end
			dsr_s6[k+1] <= dsr_s6[k];
			c_s6[k+1] <= c_s6[k];
		end
	end

	assign pct = (~outer_q[31] && (outer_q != '0)) ?
		17'(18'h10000 - 18'(q_s6[DvSteps][3])) : 17'h10000;

	always_ff @(posedge clk) begin
		mag_s7 <= 48'((64'(c_s6[DvSteps].sm) * 64'(pct)) >> 16);
		c_s7.unit <= q_s6[DvSteps][2:0];
		c_s7.neg <= c_s6[DvSteps].neg;
		c_s7.sm <= c_s6[DvSteps].sm;
		c_s7.apply <= c_s6[DvSteps].apply;
		c_s7.kill <= c_s6[DvSteps].kill;
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			f_s8[i] <= 49'((65'(mag_s7) * 65'(c_s7.unit[i])) >> 16);
		end
		c_s8 <= c_s7;
	end

	// saturation, and zero force on a word that is not applied
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			logic ng;
			ng = c_s8.neg[i] ^ strength_q[31];
			if (!c_s8.apply) begin
				sat[i] = '0;
			end else if (ng) begin
				sat[i] = (f_s8[i] >= 49'h80000000) ? 32'h80000000 : 32'(-f_s8[i]);
			end else begin
				sat[i] = (f_s8[i] >= 49'h7fffffff) ? 32'h7fffffff : f_s8[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		out_q.force_x <= sat[0];
		out_q.force_y <= sat[1];
		out_q.force_z <= sat[2];
		out_q.apply_force <= c_s8.apply;
		out_q.kill_particle <= c_s8.kill;
	end

endmodule

@@ rtl/rrf_checker.sv @@
// ----------------------------------------------------------------------------
// rrf_checker
// Port-level checks of the radial repulsion force unit.
// ----------------------------------------------------------------------------
module rrf_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                busy,
	input logic                done,
	input rrf_pkg::out_word_t  result
);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_zero_unless_applied: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.apply_force |->
		result.force_x == '0 && result.force_y == '0 && result.force_z == '0)
		else $error("force on a word that is not applied");

	a_apply_kill_excl: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.apply_force && result.kill_particle))
		else $error("word both applied and killed");

endmodule

bind radial_repulsion_force_unit rrf_checker u_rrf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.busy(busy),
	.done(done),
	.result(result)
);
